>>> rtl/adsrh_pkg.sv
// Shared constants, types and the sequencer microprogram for the ADSR-with-hold envelope.
package adsrh_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 24;
    localparam int AMP_W       = FRAC_BITS + 1;
    localparam int HOLD_W      = 24;
    localparam int CFG_W       = AMP_W;
    localparam int CFG_IDX_W   = 3;
    localparam int MUL_W       = ((SAMPLE_BITS > AMP_W) ? SAMPLE_BITS : AMP_W) + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int SCL_W       = PROD_W - FRAC_BITS;
    localparam int PC_W        = 3;
    localparam int PROG_LEN    = 8;

    localparam logic [AMP_W-1:0] FULL_SCALE = {1'b1, {FRAC_BITS{1'b0}}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_FACTOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_SAMPLES   = 3'd4;

    localparam logic [AMP_W-1:0]  RST_ATTACK_STEP    = AMP_W'(16777);
    localparam logic [AMP_W-1:0]  RST_DECAY_FACTOR   = AMP_W'(16770000);
    localparam logic [AMP_W-1:0]  RST_SUSTAIN_LEVEL  = AMP_W'(8388608);
    localparam logic [AMP_W-1:0]  RST_RELEASE_FACTOR = AMP_W'(16770000);
    localparam logic [HOLD_W-1:0] RST_HOLD_SAMPLES   = HOLD_W'(1);

    typedef struct packed {
        logic release_ph;
        logic sustain_ph;
        logic hold_ph;
        logic decay_ph;
        logic attack_ph;
    } phase_t;

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_MUL_DEC = 3'd1,
        OP_DEC_WB  = 3'd2,
        OP_HOLD    = 3'd3,
        OP_MUL_REL = 3'd4,
        OP_REL_WB  = 3'd5,
        OP_MUL_OUT = 3'd6,
        OP_OUT_WB  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        COND_NEXT       = 2'd0,
        COND_NO_DECAY   = 2'd1,
        COND_NO_RELEASE = 2'd2,
        COND_END        = 2'd3
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ucode_t;

    localparam logic [PC_W-1:0] LBL_NONE = 3'd0;
    localparam logic [PC_W-1:0] LBL_HOLD = 3'd3;
    localparam logic [PC_W-1:0] LBL_OUT  = 3'd6;

    localparam ucode_t PROGRAM [PROG_LEN] = '{
        '{OP_START,   COND_NO_DECAY,   LBL_HOLD},
        '{OP_MUL_DEC, COND_NEXT,       LBL_NONE},
        '{OP_DEC_WB,  COND_NEXT,       LBL_NONE},
        '{OP_HOLD,    COND_NO_RELEASE, LBL_OUT},
        '{OP_MUL_REL, COND_NEXT,       LBL_NONE},
        '{OP_REL_WB,  COND_NEXT,       LBL_NONE},
        '{OP_MUL_OUT, COND_NEXT,       LBL_NONE},
        '{OP_OUT_WB,  COND_END,        LBL_NONE}
    };

endpackage

>>> rtl/adsr_envelope_with_hold.sv
// ADSR envelope with hold stage: microcoded sequencer around one shared multiplier.
// Each request runs the microprogram from accept to out_valid; decay and release steps
// each pass through the shared 26x26 multiplier, skipped when not needed.
// One request in flight; in_stall drops as out_valid rises.
// The last step waits while the previous result is still stalled at the output.
// Async reset clears phases, amplitude, hold counter and output; registers load defaults.
module adsr_envelope_with_hold
    import adsrh_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_wen,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_wdata,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          gate,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out
);

    logic [AMP_W-1:0]  attack_step_reg;
    logic [AMP_W-1:0]  decay_factor_reg;
    logic [AMP_W-1:0]  sustain_level_reg;
    logic [AMP_W-1:0]  release_factor_reg;
    logic [HOLD_W-1:0] hold_samples_reg;

    phase_t                          flags_reg, flags_next;
    logic [AMP_W-1:0]                amp_reg, amp_next;
    logic [HOLD_W-1:0]               hc_reg, hc_next;
    logic signed [SAMPLE_BITS-1:0]   last_reg, last_next;
    logic                            shape_reg, shape_next;
    logic [PC_W-1:0]                 pc_reg, pc_next;
    logic                            run_reg, run_next;
    logic                            out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0]   smp_reg;
    logic                            gate_reg;
    logic signed [PROD_W-1:0]        prod_reg;

    ucode_t                  uw;
    logic                    accept;
    logic                    out_free;
    logic                    take_jump;
    logic                    mul_en;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic [AMP_W:0]          attack_sum;
    logic [SCL_W-1:0]        scaled;
    logic [AMP_W-1:0]        amp_scaled;

    assign in_stall   = run_reg;
    assign accept     = in_valid && !run_reg;
    assign out_valid  = out_valid_reg;
    assign sample_out = last_reg;
    assign out_free   = !(out_valid_reg && out_stall);

    assign uw = PROGRAM[pc_reg];

    assign attack_sum = {1'b0, amp_reg} + {1'b0, attack_step_reg};
    assign scaled     = prod_reg[PROD_W-1:FRAC_BITS];
    assign amp_scaled = (scaled > SCL_W'(FULL_SCALE)) ? FULL_SCALE : scaled[AMP_W-1:0];

    // shared multiplier operand select
    always_comb
    begin
        mul_en = run_reg && (uw.op inside {OP_MUL_DEC, OP_MUL_REL, OP_MUL_OUT});
        case (uw.op)
            OP_MUL_DEC:
            begin
                mul_a = $signed({{(MUL_W-AMP_W){1'b0}}, amp_reg});
                mul_b = $signed({{(MUL_W-AMP_W){1'b0}}, decay_factor_reg});
            end
            OP_MUL_REL:
            begin
                mul_a = $signed({{(MUL_W-AMP_W){1'b0}}, amp_reg});
                mul_b = $signed({{(MUL_W-AMP_W){1'b0}}, release_factor_reg});
            end
            default:
            begin
                mul_a = MUL_W'(smp_reg);
                mul_b = $signed({{(MUL_W-AMP_W){1'b0}}, amp_reg});
            end
        endcase
    end

    always_comb
    begin
        flags_next     = flags_reg;
        amp_next       = amp_reg;
        hc_next        = hc_reg;
        last_next      = last_reg;
        shape_next     = shape_reg;
        pc_next        = pc_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg && out_stall;
        take_jump      = 1'b0;

        if (accept)
        begin
            run_next = 1'b1;
            pc_next  = '0;
        end
        else if (run_reg)
        begin
            case (uw.op)
                OP_START:
                begin
                    shape_next = 1'b0;
                    if (gate_reg && !(flags_reg.attack_ph || flags_reg.hold_ph
                                      || flags_reg.decay_ph))
                    begin
                        hc_next              = '0;
                        flags_next           = '0;
                        flags_next.attack_ph = 1'b1;
                    end
                    if (flags_next.attack_ph)
                    begin
                        flags_next.release_ph = 1'b0;
                        amp_next   = (attack_sum > {1'b0, FULL_SCALE}) ? FULL_SCALE
                                                                      : attack_sum[AMP_W-1:0];
                        shape_next = 1'b1;
                        if (attack_sum >= {1'b0, FULL_SCALE})
                        begin
                            flags_next.attack_ph = 1'b0;
                            flags_next.decay_ph  = 1'b1;
                        end
                    end
                end
                OP_DEC_WB:
                begin
                    amp_next   = amp_scaled;
                    shape_next = 1'b1;
                    if (amp_scaled <= sustain_level_reg)
                    begin
                        flags_next.decay_ph = 1'b0;
                        flags_next.hold_ph  = 1'b1;
                    end
                end
                OP_HOLD:
                begin
                    if (hc_reg < hold_samples_reg && flags_reg.hold_ph)
                    begin
                        shape_next = 1'b1;
                        hc_next    = hc_reg + HOLD_W'(1);
                    end
                    if (hc_next >= hold_samples_reg)
                    begin
                        if (gate_reg)
                        begin
                            shape_next = 1'b1;
                        end
                        else
                        begin
                            flags_next.hold_ph    = 1'b0;
                            flags_next.release_ph = 1'b1;
                        end
                    end
                end
                OP_REL_WB:
                begin
                    amp_next   = amp_scaled;
                    shape_next = 1'b1;
                end
                OP_OUT_WB:
                begin
                    // previous result must leave before last_reg moves
                    if (out_free && shape_reg)
                    begin
                        last_next = prod_reg[FRAC_BITS +: SAMPLE_BITS];
                    end
                end
                default:
                begin
                end
            endcase

            case (uw.cond)
                COND_NO_DECAY:   take_jump = !flags_next.decay_ph;
                COND_NO_RELEASE: take_jump = !(flags_next.release_ph && amp_reg != '0);
                default:         take_jump = 1'b0;
            endcase

            if (uw.cond == COND_END)
            begin
                if (out_free)
                begin
                    run_next       = 1'b0;
                    out_valid_next = 1'b1;
                end
            end
            else if (take_jump)
            begin
                pc_next = uw.target;
            end
            else
            begin
                pc_next = pc_reg + PC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_step_reg    <= RST_ATTACK_STEP;
            decay_factor_reg   <= RST_DECAY_FACTOR;
            sustain_level_reg  <= RST_SUSTAIN_LEVEL;
            release_factor_reg <= RST_RELEASE_FACTOR;
            hold_samples_reg   <= RST_HOLD_SAMPLES;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_ATTACK_STEP:    attack_step_reg    <= cfg_wdata[AMP_W-1:0];
                REG_DECAY_FACTOR:   decay_factor_reg   <= cfg_wdata[AMP_W-1:0];
                REG_SUSTAIN_LEVEL:  sustain_level_reg  <= cfg_wdata[AMP_W-1:0];
                REG_RELEASE_FACTOR: release_factor_reg <= cfg_wdata[AMP_W-1:0];
                REG_HOLD_SAMPLES:   hold_samples_reg   <= cfg_wdata[HOLD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            amp_reg       <= '0;
            hc_reg        <= '0;
            last_reg      <= '0;
            shape_reg     <= 1'b0;
            pc_reg        <= '0;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            flags_reg     <= flags_next;
            amp_reg       <= amp_next;
            hc_reg        <= hc_next;
            last_reg      <= last_next;
            shape_reg     <= shape_next;
            pc_reg        <= pc_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_reg  <= sample_in;
            gate_reg <= gate;
        end
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

endmodule
